FILE: design/u8s_pkg.sv
// Shared types and constants of the UTF-8 sanitiser stream.
package u8s_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [7:0] REPL_RESET = 8'h3F;

  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] SEC_A0    = 8'hA0;
  localparam logic [7:0] SEC_90    = 8'h90;
  localparam logic [7:0] SEC_8F    = 8'h8F;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // All result bytes caused by one input item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            text_end;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: design/u8s_front.sv
// Front part: accept bytes, track the held sequence and build each run.
module u8s_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8s_pkg::in_item_t in_data,
  input  logic [7:0]        repl_byte,
  input  u8s_pkg::q_status_t q_stat,
  output logic              q_push,
  output u8s_pkg::run_t     q_wdata
);

  logic [7:0] pend_r [0:2];
  logic [7:0] pend_nxt [0:2];
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [2:0] elen_r, elen_nxt;
  logic       accept;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= u8s_pkg::LEAD2_LO && b <= u8s_pkg::LEAD2_HI) len = 3'd2;
    else if (b >= u8s_pkg::LEAD3_LO && b <= u8s_pkg::LEAD3_HI) len = 3'd3;
    else if (b >= u8s_pkg::LEAD4_LO && b <= u8s_pkg::LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == u8s_pkg::LEAD3_LO) ok = (b >= u8s_pkg::SEC_A0);
    else if (lead == u8s_pkg::LEAD_SURR) ok = (b < u8s_pkg::SEC_A0);
    else if (lead == u8s_pkg::LEAD4_LO) ok = (b >= u8s_pkg::SEC_90);
    else if (lead == u8s_pkg::LEAD4_HI) ok = (b <= u8s_pkg::SEC_8F);
    return ok;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0] b;
    logic       cont;
    logic       consumed;
    logic [2:0] n;
    logic [2:0] len;
    b        = in_data.in_byte;
    cont     = ((b & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_TAG);
    consumed = 1'b0;
    n        = 3'd0;
    len      = lead_len(b);
    q_wdata  = '0;
    pcnt_nxt = pcnt_r;
    elen_nxt = elen_r;
    for (int k = 0; k < 3; k++) pend_nxt[k[1:0]] = pend_r[k[1:0]];

    if (pcnt_r != 2'd0) begin
      if (cont && (pcnt_r != 2'd1 || second_ok(pend_r[0], b))) begin
        consumed = 1'b1;
        if (({1'b0, pcnt_r} + 3'd1) >= elen_r) begin
          // sequence complete: release held bytes and this one unchanged
          for (int k = 0; k < 3; k++) begin
            if (k < int'(pcnt_r)) q_wdata.bytes[k[1:0]] = pend_r[k[1:0]];
          end
          q_wdata.bytes[pcnt_r] = b;
          n        = {1'b0, pcnt_r} + 3'd1;
          pcnt_nxt = 2'd0;
          elen_nxt = 3'd0;
        end else begin
          if (pcnt_r != 2'd3) pend_nxt[pcnt_r] = b;
          pcnt_nxt = pcnt_r + 2'd1;
        end
      end else begin
        // failed sequence: every held byte becomes a replacement
        for (int k = 0; k < 3; k++) begin
          if (k < int'(pcnt_r)) q_wdata.bytes[k[1:0]] = repl_byte;
        end
        n        = {1'b0, pcnt_r};
        pcnt_nxt = 2'd0;
        elen_nxt = 3'd0;
      end
    end

    if (!consumed) begin
      if (!b[7]) begin
        q_wdata.bytes[n[1:0]] = b;
        n = n + 3'd1;
      end else if (len != 3'd0) begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        elen_nxt    = len;
      end else begin
        q_wdata.bytes[n[1:0]] = repl_byte;
        n = n + 3'd1;
      end
    end

    if (in_data.in_end && pcnt_nxt != 2'd0) begin
      // truncated at end of text: flush held bytes as replacements
      for (int k = 0; k < 3; k++) begin
        if (k < int'(pcnt_nxt) && n < 3'd4) begin
          q_wdata.bytes[n[1:0]] = repl_byte;
          n = n + 3'd1;
        end
      end
      pcnt_nxt = 2'd0;
      elen_nxt = 3'd0;
    end

    q_wdata.cnt      = n;
    q_wdata.text_end = in_data.in_end;
    q_push           = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      elen_r <= 3'd0;
    end else if (accept) begin
      pcnt_r <= pcnt_nxt;
      elen_r <= elen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) pend_r[k[1:0]] <= pend_nxt[k[1:0]];
    end
  end

endmodule

FILE: design/u8s_queue.sv
// Short run queue between the front and back parts.
module u8s_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8s_pkg::run_t      wdata,
  input  logic               pop,
  output u8s_pkg::run_t      head,
  output u8s_pkg::q_status_t stat
);

  u8s_pkg::run_t             mem_r [0:u8s_pkg::QDEPTH-1];
  logic [u8s_pkg::QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [u8s_pkg::QAW:0]     cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (u8s_pkg::QAW+1)'(u8s_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

FILE: design/u8s_back.sv
// Back part: walk the head run one byte a cycle into the output register while it can take one.
module u8s_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8s_pkg::run_t      head,
  input  u8s_pkg::q_status_t q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8s_pkg::out_item_t out_data
);

  logic                  out_valid_r;
  u8s_pkg::out_item_t    out_data_r, out_data_nxt;
  logic [1:0]            idx_r;
  logic                  load;
  logic                  last;

  assign load = !q_stat.empty && (!out_valid_r || out_ready);
  assign last = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign q_pop = load && last;

  always_comb begin
    out_data_nxt.out_byte = head.bytes[idx_r];
    out_data_nxt.run_last = last;
    out_data_nxt.text_end = last && head.text_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load) idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/utf8_sanitizer_stream.sv
// A released result passes through the run queue and then the output register.
// Throughput: one input item per cycle while the queue has room; results leave one per cycle
// while out_ready allows, each run whole before the next, buffered by a 4-run queue.
// Input stalls only when that queue is full; held bytes live in the front part.
// Reset: synchronous, active low; clears the held sequence, queue and output valid,
// and returns the replacement byte to 0x3F.
module utf8_sanitizer_stream (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8s_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output u8s_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic [7:0]         repl_r;
  logic               q_push;
  logic               q_pop;
  u8s_pkg::run_t      q_wdata;
  u8s_pkg::run_t      q_head;
  u8s_pkg::q_status_t q_stat;

  // Configuration: always ready; the user must write it only while the stream is idle, unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= u8s_pkg::REPL_RESET;
    end else if (cfg_valid) begin
      repl_r <= cfg_data;
    end
  end

  // Front: classify each item and push the run of bytes it releases.
  u8s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .repl_byte (repl_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Queue: decouple classification from output back-pressure.
  u8s_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // Back: serialise each run, flagging its last byte and the end of text.
  u8s_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
